// File: hw/rtl/etok_pkg.sv
// Shared types and token kind codes for the expression token scanner.
package etok_pkg;

  localparam int TokFieldW = 16;
  localparam int KindW     = 4;

  localparam logic [KindW-1:0] KIND_EOF     = 4'd0;
  localparam logic [KindW-1:0] KIND_IDENT   = 4'd1;
  localparam logic [KindW-1:0] KIND_INT     = 4'd2;
  localparam logic [KindW-1:0] KIND_FLOAT   = 4'd3;
  localparam logic [KindW-1:0] KIND_PLUS    = 4'd4;
  localparam logic [KindW-1:0] KIND_MINUS   = 4'd5;
  localparam logic [KindW-1:0] KIND_MUL     = 4'd6;
  localparam logic [KindW-1:0] KIND_DIV     = 4'd7;
  localparam logic [KindW-1:0] KIND_LPAREN  = 4'd8;
  localparam logic [KindW-1:0] KIND_RPAREN  = 4'd9;
  localparam logic [KindW-1:0] KIND_ASSIGN  = 4'd10;
  localparam logic [KindW-1:0] KIND_NEWLINE = 4'd11;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 4'd12;

  localparam logic [7:0] CH_EOT   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  typedef struct packed {
    logic             is_letter;
    logic             is_digit;
    logic             is_space;
    logic             is_eot;
    logic             is_dot;
    logic             is_newline;
    logic [KindW-1:0] op_kind;
  } class_t;

  typedef struct packed {
    logic [KindW-1:0]     kind;
    logic [TokFieldW-1:0] start;
    logic [TokFieldW-1:0] len;
    logic [TokFieldW-1:0] line;
    logic                 last;
  } tok_t;

  typedef struct packed {
    logic [QueueCntW-1:0] count;
    logic                 room;
  } q_stat_t;

endpackage

// File: hw/rtl/etok_classify.sv
// Byte classifier: character classes and one-byte token kind.
module etok_classify (
  input  logic [7:0]      code,
  output etok_pkg::class_t cls
);
  import etok_pkg::*;

  always_comb begin
    cls.is_letter  = (code >= 8'h61 && code <= 8'h7a) ||
                     (code >= 8'h41 && code <= 8'h5a) || (code == CH_UNDER);
    cls.is_digit   = (code >= 8'h30 && code <= 8'h39);
    cls.is_space   = (code == CH_SPACE) || (code == CH_TAB) || (code == CH_CR);
    cls.is_eot     = (code == CH_EOT);
    cls.is_dot     = (code == CH_DOT);
    cls.is_newline = (code == CH_LF);
    case (code)
      8'h2b:   cls.op_kind = KIND_PLUS;
      8'h2d:   cls.op_kind = KIND_MINUS;
      8'h2a:   cls.op_kind = KIND_MUL;
      8'h2f:   cls.op_kind = KIND_DIV;
      8'h28:   cls.op_kind = KIND_LPAREN;
      8'h29:   cls.op_kind = KIND_RPAREN;
      8'h3d:   cls.op_kind = KIND_ASSIGN;
      CH_LF:   cls.op_kind = KIND_NEWLINE;
      default: cls.op_kind = KIND_UNKNOWN;
    endcase
  end

endmodule

// File: hw/rtl/etok_core.sv
// Scan state and token generation: up to two tokens per byte.
module etok_core #(
  parameter int PW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  etok_pkg::class_t cls,
  output etok_pkg::tok_t   res0,
  output etok_pkg::tok_t   res1,
  output logic [1:0]       res_count
);
  import etok_pkg::*;

  typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FRAC} mode_t;

  localparam logic [PW-1:0] CntMax = {PW{1'b1}};
  localparam logic [PW-1:0] One    = {{(PW-1){1'b0}}, 1'b1};

  mode_t         mode, mode_next;
  logic [PW-1:0] token_start, token_start_next;
  logic [PW-1:0] byte_position, byte_position_next;
  logic [PW-1:0] line_count, line_count_next;

  logic [PW-1:0]    pos_inc, line_inc, close_len;
  logic             extend, have_close, have_second;
  logic [KindW-1:0] close_kind;
  tok_t             close_tok, sec_tok;

  function automatic tok_t mk_tok(logic [KindW-1:0] kind, logic [PW-1:0] start,
                                  logic [PW-1:0] len, logic [PW-1:0] line);
    logic [31:0] s32, l32, n32;
    tok_t        t;
    s32 = 32'(start);
    l32 = 32'(len);
    n32 = 32'(line);
    t.kind  = kind;
    t.start = s32[TokFieldW-1:0];
    t.len   = l32[TokFieldW-1:0];
    t.line  = n32[TokFieldW-1:0];
    t.last  = 1'b0;
    return t;
  endfunction

  assign pos_inc   = (byte_position == CntMax) ? CntMax : byte_position + One;
  assign line_inc  = (line_count == CntMax) ? CntMax : line_count + One;
  assign close_len = (byte_position >= token_start) ? byte_position - token_start : '0;

  always_comb begin
    unique case (mode)
      MODE_IDLE:  begin extend = 1'b0;                           close_kind = KIND_EOF;   end
      MODE_IDENT: begin extend = cls.is_letter || cls.is_digit;  close_kind = KIND_IDENT; end
      MODE_INT:   begin extend = cls.is_digit || cls.is_dot;     close_kind = KIND_INT;   end
      MODE_FRAC:  begin extend = cls.is_digit;                   close_kind = KIND_FLOAT; end
      default:    begin extend = 1'b0;                           close_kind = KIND_EOF;   end
    endcase
  end

  always_comb begin
    mode_next          = mode;
    token_start_next   = token_start;
    byte_position_next = byte_position;
    line_count_next    = line_count;
    have_close         = 1'b0;
    have_second        = 1'b0;
    close_tok          = mk_tok(close_kind, token_start, close_len, line_count);
    sec_tok            = mk_tok(KIND_EOF, byte_position, '0, line_count);
    if (mode != MODE_IDLE && extend) begin
      byte_position_next = pos_inc;
      if (mode == MODE_INT && cls.is_dot) begin
        mode_next = MODE_FRAC;
      end
    end else begin
      if (mode != MODE_IDLE) begin
        have_close = 1'b1;
        mode_next  = MODE_IDLE;
      end
      if (cls.is_eot) begin
        have_second        = 1'b1;
        byte_position_next = '0;
        line_count_next    = One;
      end else if (cls.is_space) begin
        byte_position_next = pos_inc;
      end else if (cls.is_letter || cls.is_digit) begin
        mode_next          = cls.is_digit ? MODE_INT : MODE_IDENT;
        token_start_next   = byte_position;
        byte_position_next = pos_inc;
      end else begin
        have_second        = 1'b1;
        byte_position_next = pos_inc;
        if (cls.is_newline) begin
          line_count_next = line_inc;
        end
        sec_tok = mk_tok(cls.op_kind, byte_position, One,
                         cls.is_newline ? line_inc : line_count);
      end
    end
  end

  always_comb begin
    if (have_close) begin
      res0      = close_tok;
      res1      = sec_tok;
      res_count = have_second ? 2'd2 : 2'd1;
    end else begin
      res0      = sec_tok;
      res1      = sec_tok;
      res_count = have_second ? 2'd1 : 2'd0;
    end
    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      token_start   <= '0;
      byte_position <= '0;
      line_count    <= One;
    end else if (fire) begin
      mode          <= mode_next;
      token_start   <= token_start_next;
      byte_position <= byte_position_next;
      line_count    <= line_count_next;
    end
  end

endmodule

// File: hw/rtl/etok_queue.sv
// Four-entry result queue taking up to two tokens per cycle, giving one.
module etok_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  etok_pkg::tok_t    push0,
  input  etok_pkg::tok_t    push1,
  input  logic              pop,
  output etok_pkg::tok_t    head,
  output etok_pkg::q_stat_t stat
);
  import etok_pkg::*;

  tok_t                 mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr, wr_ptr_alt;
  logic [QueueCntW-1:0] count;

  assign wr_ptr_alt = wr_ptr + QueuePtrW'(1);
  assign head       = mem[rd_ptr];
  assign stat.count = count;
  assign stat.room  = (count <= QueueCntW'(QueueDepth - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_alt] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrW'(push_count);
      rd_ptr <= rd_ptr + QueuePtrW'(pop);
      count  <= count + QueueCntW'(push_count) - QueueCntW'(pop);
    end
  end

endmodule

// File: hw/rtl/expression_token_scanner.sv
// Top level of the expression token scanner.
//
// Takes one text byte per transaction on s_* (byte 0 ends the text) and gives
// one token per transaction on m_*, with m_tlast set on the last token caused
// by a byte. A byte is taken every cycle as long as the four-entry result
// queue has room for two tokens; a byte that gives two tokens (a closing
// identifier or number plus a one-byte or end-of-text token) needs an output
// transaction for each, so sustained input rate is one byte per cycle up to
// the output token rate. A byte waits in the input register until the queue
// has room. Positions and line counts are POSITION_WIDTH bits wide and
// saturate; the output fields carry their low 16 bits.
module expression_token_scanner #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [3:0] token_kind, [19:4] start_position,
                                 // [35:20] token_length, [51:36] line_number
  output logic        m_tlast
);
  import etok_pkg::*;

  logic       in_valid;
  logic [7:0] in_code;
  logic       fire, pop;
  logic [1:0] res_count, push_count;
  class_t     cls;
  tok_t       res0, res1, head;
  q_stat_t    stat;

  assign fire       = in_valid && stat.room;
  assign s_tready   = !in_valid || fire;
  assign push_count = fire ? res_count : 2'd0;
  assign m_tvalid   = (stat.count != '0);
  assign pop        = m_tvalid && m_tready;
  assign m_tdata    = {4'b0, head.line, head.len, head.start, head.kind};
  assign m_tlast    = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata;
    end
  end

  etok_classify u_classify (
    .code (in_code),
    .cls  (cls)
  );

  etok_core #(.PW(POSITION_WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .cls       (cls),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  etok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= QueueCntW'(QueueDepth))
    else $error("result queue overflow");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= KIND_UNKNOWN)
    else $error("token kind out of range");

  a_eof_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3:0] == KIND_EOF) |-> (m_tdata[35:20] == '0 && m_tlast))
    else $error("eof token malformed");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && !stat.room))
    else $error("input stalled without cause");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for expression_token_scanner: directed and random byte streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import etok_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int REPORT_MAX = 10;
  localparam logic [15:0] CNT_MAX = 16'hffff;

  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_MUL    = "*";
  localparam logic [7:0] CH_DIV    = "/";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_ASSIGN = "=";

  localparam logic [6:0][7:0] OP_CHARS =
    {CH_ASSIGN, CH_RPAREN, CH_LPAREN, CH_DIV, CH_MUL, CH_MINUS, CH_PLUS};
  localparam logic [2:0][7:0] BLANK_CHARS = {CH_CR, CH_TAB, CH_SPACE};

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_FRAC} scan_mode_e;

  typedef struct {
    logic [7:0]       ch;
    bit               fixed;
    logic [KindW-1:0] kind;
    logic [15:0]      start;
    logic [15:0]      len;
    logic [15:0]      line;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;

  // typed expectation travels with the byte it belongs to
  logic row_fixed = 1'b0;
  tok_t row_tok = '0;

  scan_mode_e  mode_q = SCAN_IDLE;
  logic [15:0] tok_start_q = '0;
  logic [15:0] pos_q = '0;
  logic [15:0] line_q = 16'd1;
  tok_t        expected_toks[$];
  tok_t        step_toks[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_taken = 0;
  int unsigned tokens_seen = 0;
  int unsigned eof_seen = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  dir_row_t dir_tab [28];

  expression_token_scanner u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic tok_t make_tok(input logic [KindW-1:0] kind, input logic [15:0] start,
                                    input logic [15:0] len, input logic [15:0] line);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.last  = 1'b0;
    return t;
  endfunction

  // Advances the scanner state by one byte; the tokens it closes land in step_toks.
  function automatic void scan_byte(input logic [7:0] c);
    bit extend;
    logic [KindW-1:0] kind;
    logic [15:0] here;
    tok_t t;
    step_toks.delete();
    if (mode_q != SCAN_IDLE) begin
      case (mode_q)
        SCAN_IDENT: extend = is_letter(c) || is_digit(c);
        SCAN_INT: begin
          extend = is_digit(c) || c == CH_DOT;
          if (c == CH_DOT) mode_q = SCAN_FRAC;
        end
        default: extend = is_digit(c);
      endcase
      if (extend) begin
        pos_q = sat_inc(pos_q);
        return;
      end
      kind = (mode_q == SCAN_IDENT) ? KIND_IDENT : (mode_q == SCAN_INT) ? KIND_INT : KIND_FLOAT;
      step_toks.push_back(make_tok(kind, tok_start_q,
                                   (pos_q >= tok_start_q) ? pos_q - tok_start_q : 16'd0, line_q));
      mode_q = SCAN_IDLE;
    end
    if (c == CH_EOT) begin
      step_toks.push_back(make_tok(KIND_EOF, pos_q, 16'd0, line_q));
      pos_q  = '0;
      line_q = 16'd1;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      pos_q = sat_inc(pos_q);
    end else if (is_letter(c) || is_digit(c)) begin
      mode_q      = is_digit(c) ? SCAN_INT : SCAN_IDENT;
      tok_start_q = pos_q;
      pos_q       = sat_inc(pos_q);
    end else begin
      here = pos_q;
      case (c)
        CH_PLUS:   kind = KIND_PLUS;
        CH_MINUS:  kind = KIND_MINUS;
        CH_MUL:    kind = KIND_MUL;
        CH_DIV:    kind = KIND_DIV;
        CH_LPAREN: kind = KIND_LPAREN;
        CH_RPAREN: kind = KIND_RPAREN;
        CH_ASSIGN: kind = KIND_ASSIGN;
        CH_LF:     kind = KIND_NEWLINE;
        default:   kind = KIND_UNKNOWN;
      endcase
      pos_q = sat_inc(pos_q);
      if (c == CH_LF) line_q = sat_inc(line_q);
      step_toks.push_back(make_tok(kind, here, 16'd1, line_q));
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
  endfunction

  task automatic report(input string what, input tok_t want, input tok_t got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("%0t %s: expected kind %0d start %0d len %0d line %0d last %0b,",
               $realtime, what, want.kind, want.start, want.len, want.line, want.last,
               " got kind %0d start %0d len %0d line %0d last %0b",
               got.kind, got.start, got.len, got.line, got.last);
  endtask

  // Predict on every accepted byte, check on every accepted token.
  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (rst) begin
      mode_q      = SCAN_IDLE;
      tok_start_q = '0;
      pos_q       = '0;
      line_q      = 16'd1;
    end else begin
      if (s_tvalid && s_tready) begin
        bytes_taken++;
        scan_byte(s_tdata);
        if (row_fixed) begin
          want = row_tok;
          want.last = 1'b1;
          expected_toks.push_back(want);
        end else begin
          foreach (step_toks[i]) expected_toks.push_back(step_toks[i]);
        end
      end
      if (m_tvalid && m_tready) begin
        got.kind  = m_tdata[3:0];
        got.start = m_tdata[19:4];
        got.len   = m_tdata[35:20];
        got.line  = m_tdata[51:36];
        got.last  = m_tlast;
        tokens_seen++;
        if (got.kind == KIND_EOF) eof_seen++;
        if (expected_toks.size() == 0) begin
          report("unexpected token", got, got);
        end else begin
          want = expected_toks.pop_front();
          if (got.kind != want.kind || got.start != want.start || got.len != want.len ||
              got.line != want.line || got.last != want.last)
            report("token mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d tokens pending",
               STALL_LIMIT, expected_toks.size());
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] ch, input bit fixed = 1'b0,
                           input tok_t ftok = '0);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= ch;
    row_fixed <= fixed;
    row_tok   <= ftok;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_letter();
    int unsigned r;
    r = $urandom_range(52);
    if (r == 52) return CH_UNDER;
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // Mostly well-formed expression text, with some noise bytes and ends of text.
  task automatic emit_random_token();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 22) begin
      send_byte(pick_letter());
      n = $urandom_range(6);
      repeat (n) send_byte(($urandom_range(3) == 0) ? pick_digit() : pick_letter());
    end else if (r < 47) begin
      n = $urandom_range(5, 1);
      repeat (n) send_byte(pick_digit());
      if (r >= 37) begin
        send_byte(CH_DOT);
        n = $urandom_range(3);
        repeat (n) send_byte(pick_digit());
      end
    end else if (r < 72) begin
      send_byte(OP_CHARS[$urandom_range(6)]);
    end else if (r < 82) begin
      send_byte(BLANK_CHARS[$urandom_range(2)]);
    end else if (r < 88) begin
      send_byte(CH_LF);
    end else if (r < 96) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(CH_EOT);
    end
  endtask

  initial begin
    dir_tab = '{
      '{CH_PLUS,   1, KIND_PLUS,    0, 1, 1},
      '{CH_MINUS,  1, KIND_MINUS,   1, 1, 1},
      '{CH_MUL,    1, KIND_MUL,     2, 1, 1},
      '{CH_DIV,    1, KIND_DIV,     3, 1, 1},
      '{CH_LPAREN, 1, KIND_LPAREN,  4, 1, 1},
      '{CH_RPAREN, 1, KIND_RPAREN,  5, 1, 1},
      '{CH_ASSIGN, 1, KIND_ASSIGN,  6, 1, 1},
      '{CH_LF,     1, KIND_NEWLINE, 7, 1, 2},
      '{8'hff,     1, KIND_UNKNOWN, 8, 1, 2},
      '{8'h80,     1, KIND_UNKNOWN, 9, 1, 2},
      '{CH_SPACE,  0, KIND_EOF,     0, 0, 0},
      '{CH_TAB,    0, KIND_EOF,     0, 0, 0},
      '{CH_CR,     0, KIND_EOF,     0, 0, 0},
      '{CH_UNDER,  0, KIND_EOF,     0, 0, 0},
      '{8'h5a,     0, KIND_EOF,     0, 0, 0},
      '{8'h39,     0, KIND_EOF,     0, 0, 0},
      '{CH_PLUS,   0, KIND_EOF,     0, 0, 0},
      '{8'h30,     0, KIND_EOF,     0, 0, 0},
      '{CH_DOT,    0, KIND_EOF,     0, 0, 0},
      '{8'h35,     0, KIND_EOF,     0, 0, 0},
      '{CH_RPAREN, 0, KIND_EOF,     0, 0, 0},
      '{8'h37,     0, KIND_EOF,     0, 0, 0},
      '{CH_DOT,    0, KIND_EOF,     0, 0, 0},
      '{CH_DOT,    0, KIND_EOF,     0, 0, 0},
      '{8'h34,     0, KIND_EOF,     0, 0, 0},
      '{8'h78,     0, KIND_EOF,     0, 0, 0},
      '{CH_EOT,    0, KIND_EOF,     0, 0, 0},
      '{CH_EOT,    1, KIND_EOF,     0, 0, 1}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 21;
    snk_idle_pct = 78;
    foreach (dir_tab[k])
      send_byte(dir_tab[k].ch, dir_tab[k].fixed,
                make_tok(dir_tab[k].kind, dir_tab[k].start, dir_tab[k].len, dir_tab[k].line));
    while (bytes_sent < 300) emit_random_token();

    src_idle_pct = 78;
    snk_idle_pct = 21;
    while (bytes_sent < 600) emit_random_token();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req = 1'b1;
    while (bytes_sent < 930) emit_random_token();
    s_tvalid <= 1'b0;

    while (expected_toks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d bytes and %0d tokens (%0d end-of-text), %0d mismatches",
             bytes_taken, tokens_seen, eof_seen, errors);
    $display("stall mixes 21/78, 78/21 and none, plus a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0 && expected_toks.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/etok_pkg.sv
hw/rtl/etok_classify.sv
hw/rtl/etok_core.sv
hw/rtl/etok_queue.sv
hw/rtl/expression_token_scanner.sv
sim/tb_top.sv
